// ----- hw/rtl/smia_pkg.sv -----
// ----------------------------------------------------------------------------
// smia_pkg: segment id allocator shared definitions
// Sizes, command and status codes, and the bundles that pass between the
// sequencer and the top level.
// ----------------------------------------------------------------------------
package smia_pkg;

  localparam int MAX_SEGMENTS  = 64;
  localparam int SEGMENT_WORDS = 256;
  localparam int PROGRAM_WORDS = 4096;

  // payload field widths
  localparam int CMD_W  = 3;
  localparam int ID_W   = 7;
  localparam int OFS_W  = 12;
  localparam int LEN_W  = 13;
  localparam int ST_W   = 3;
  localparam int DATA_W = 32;

  localparam int SLOT_W     = $clog2(MAX_SEGMENTS);
  localparam int CNT_W      = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_LEN_W  = $clog2(SEGMENT_WORDS + 1);
  localparam int SEG_DEPTH  = MAX_SEGMENTS * SEGMENT_WORDS;
  localparam int SEG_ADDR_W = $clog2(SEG_DEPTH);
  localparam int PRG_ADDR_W = $clog2(PROGRAM_WORDS);
  localparam int PRG_LEN_W  = $clog2(PROGRAM_WORDS + 1);
  // common width for range compares of ids, offsets and lengths
  localparam int CMP_W      = 18;

  typedef enum logic [CMD_W-1:0] {
    CMD_MAP, CMD_UNMAP, CMD_PUT, CMD_GET,
    CMD_PUT_PRG, CMD_GET_PRG, CMD_SWITCH, CMD_SET_LEN
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK, ST_NO_FREE, ST_TOO_LONG, ST_NOT_MAPPED, ST_OFFSET
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_FILL, S_READ, S_COPY, S_DRAIN
  } state_e;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   segment_id;
    logic [OFS_W-1:0]  offset;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic              done;
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] data;
  } rsp_t;

  typedef struct packed {
    logic                  we;
    logic [SEG_ADDR_W-1:0] waddr;
    logic [DATA_W-1:0]     wdata;
    logic [SEG_ADDR_W-1:0] raddr;
  } seg_req_t;

  typedef struct packed {
    logic                  we;
    logic [PRG_ADDR_W-1:0] waddr;
    logic [DATA_W-1:0]     wdata;
    logic [PRG_ADDR_W-1:0] raddr;
  } prg_req_t;

  typedef struct packed {
    logic                 we;
    logic [SLOT_W-1:0]    waddr;
    logic [SEG_LEN_W-1:0] wdata;
    logic [SLOT_W-1:0]    raddr;
  } len_req_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] waddr;
    logic [SLOT_W-1:0] wdata;
    logic [SLOT_W-1:0] raddr;
  } stk_req_t;

  // slot named by an id (id minus one); only meaningful for ids in range
  function automatic logic [SLOT_W-1:0] slot_of(logic [ID_W-1:0] id);
    logic [CMP_W-1:0] ext;
    ext = CMP_W'(id) - CMP_W'(1);
    return ext[SLOT_W-1:0];
  endfunction

  function automatic logic [SEG_ADDR_W-1:0] base_of(logic [SLOT_W-1:0] slot);
    return SEG_ADDR_W'(slot) * SEG_ADDR_W'(SEGMENT_WORDS);
  endfunction

endpackage

// ----- hw/rtl/smia_if.sv -----
// ----------------------------------------------------------------------------
// smia_cmd_if / smia_rsp_if: command and response channels
// Valid/ready channels; a beat moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface smia_cmd_if import smia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   segment_id;
  logic [OFS_W-1:0]  offset;
  logic [LEN_W-1:0]  length;
  logic [DATA_W-1:0] value;

  modport source (output valid, command, segment_id, offset, length, value,
                  input ready);
  modport sink   (input valid, command, segment_id, offset, length, value,
                  output ready);
endinterface

interface smia_rsp_if import smia_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [DATA_W-1:0] data;

  modport source (output valid, status, data, input ready);
  modport sink   (input valid, status, data, output ready);
endinterface

// ----- hw/rtl/segmented_memory_id_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// segmented_memory_id_allocator_unit: segmented word memory with id allocator
// Command in, one response beat out per command.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i  carries one command beat (map, unmap, put, get, program put/get,
//          switch, set program length). rsp_o returns exactly one beat per
//          command with a status and a data word.
//   Set length, unmap, puts and errors produce their result in the look state;
//   gets add a read state; a map of length L adds a fill of L words and a
//   switch of length L a copy of L words and a drain state (neither when L is 0).
//   The fill and copy loops move one word per cycle through the single
//   write port of the segment or program RAM. One command is in flight at
//   a time; the next is taken the cycle after the response beat leaves.
//   Reset empties the response register, unmaps every segment, empties the
//   free stack and sets the program length to zero. RAM contents are not
//   cleared; words are only read back inside lengths that were written.
//   When the receiver stalls, the response holds in its register and no
//   further command is accepted.
// ----------------------------------------------------------------------------
module segmented_memory_id_allocator_unit import smia_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  smia_cmd_if.sink   cmd_i,
  smia_rsp_if.source rsp_o
);

  cmd_t     cmd;
  rsp_t     rsp;
  logic     idle, start;
  seg_req_t seg_req;
  prg_req_t prg_req;
  len_req_t len_req;
  stk_req_t stk_req;
  logic [DATA_W-1:0]    seg_rdata, prg_rdata;
  logic [SEG_LEN_W-1:0] len_rdata;
  logic [SLOT_W-1:0]    stk_rdata;

  // response register
  logic              out_valid_q, out_valid_d;
  logic [ST_W-1:0]   out_status_q;
  logic [DATA_W-1:0] out_data_q;

  assign cmd = '{command: cmd_i.command, segment_id: cmd_i.segment_id,
                 offset: cmd_i.offset, length: cmd_i.length, value: cmd_i.value};

  // wait for an empty response slot so a result never has to stall inside
  assign cmd_i.ready = idle && !out_valid_q;
  assign start       = cmd_i.valid && cmd_i.ready;

  smia_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .cmd_i       (cmd),
    .idle_o      (idle),
    .rsp_o       (rsp),
    .seg_req_o   (seg_req),
    .seg_rdata_i (seg_rdata),
    .prg_req_o   (prg_req),
    .prg_rdata_i (prg_rdata),
    .len_req_o   (len_req),
    .len_rdata_i (len_rdata),
    .stk_req_o   (stk_req),
    .stk_rdata_i (stk_rdata)
  );

  // segment words, all slots back to back
  smia_ram #(.WIDTH(DATA_W), .DEPTH(SEG_DEPTH)) u_seg_ram (
    .clk_i (clk_i), .we_i (seg_req.we), .waddr_i (seg_req.waddr),
    .wdata_i (seg_req.wdata), .raddr_i (seg_req.raddr), .rdata_o (seg_rdata)
  );

  smia_ram #(.WIDTH(DATA_W), .DEPTH(PROGRAM_WORDS)) u_prg_ram (
    .clk_i (clk_i), .we_i (prg_req.we), .waddr_i (prg_req.waddr),
    .wdata_i (prg_req.wdata), .raddr_i (prg_req.raddr), .rdata_o (prg_rdata)
  );

  // per-slot lengths
  smia_ram #(.WIDTH(SEG_LEN_W), .DEPTH(MAX_SEGMENTS)) u_len_ram (
    .clk_i (clk_i), .we_i (len_req.we), .waddr_i (len_req.waddr),
    .wdata_i (len_req.wdata), .raddr_i (len_req.raddr), .rdata_o (len_rdata)
  );

  // LIFO of unmapped slots
  smia_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_SEGMENTS)) u_stk_ram (
    .clk_i (clk_i), .we_i (stk_req.we), .waddr_i (stk_req.waddr),
    .wdata_i (stk_req.wdata), .raddr_i (stk_req.raddr), .rdata_o (stk_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.valid && rsp_o.ready) out_valid_d = 1'b0;
    if (rsp.done) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.done) begin
      out_status_q <= rsp.status;
      out_data_q   <= rsp.data;
    end
  end

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.status = out_status_q;
  assign rsp_o.data   = out_data_q;

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.done |-> !out_valid_q)
    else $error("result produced while the response register is full");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !rsp_o.valid)
    else $error("response beat in the cycle right after a command beat");
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !idle |-> !cmd_i.ready)
    else $error("command channel ready while busy");

endmodule

// ----- hw/rtl/smia_ram.sv -----
// ----------------------------------------------------------------------------
// smia_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smia_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/smia_ctrl.sv -----
// ----------------------------------------------------------------------------
// smia_ctrl: command sequencer
// Decodes one command, drives the memories and walks fill and copy loops
// one word per cycle with a shared address counter.
// ----------------------------------------------------------------------------
module smia_ctrl import smia_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  cmd_t                 cmd_i,
  output logic                 idle_o,
  output rsp_t                 rsp_o,
  output seg_req_t             seg_req_o,
  input  logic [DATA_W-1:0]    seg_rdata_i,
  output prg_req_t             prg_req_o,
  input  logic [DATA_W-1:0]    prg_rdata_i,
  output len_req_t             len_req_o,
  input  logic [SEG_LEN_W-1:0] len_rdata_i,
  output stk_req_t             stk_req_o,
  input  logic [SLOT_W-1:0]    stk_rdata_i
);

  state_e                  state_q, state_d;
  cmd_t                    cmd_q, cmd_d;
  logic [SLOT_W-1:0]       slot_q, slot_d;
  logic [SEG_ADDR_W-1:0]   base_q, base_d;
  logic [SEG_LEN_W-1:0]    wcnt_q, wcnt_d;
  logic [SEG_LEN_W-1:0]    wlen_q, wlen_d;
  logic [MAX_SEGMENTS-1:0] mapped_q, mapped_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        fresh_q, fresh_d;
  logic [PRG_LEN_W-1:0]    plen_q, plen_d;
  logic                    cp_wr_q, cp_wr_d;
  logic [PRG_ADDR_W-1:0]   cp_waddr_q, cp_waddr_d;
  logic                    rd_prg_q, rd_prg_d;

  // decode of the latched command
  logic [CMP_W-1:0]  id_ext;
  logic [SLOT_W-1:0] id_slot;
  logic              id_mapped;
  logic              ofs_in_seg, ofs_in_prg;
  logic              map_long, map_pop, map_fresh, map_ok;
  logic [SLOT_W-1:0] map_slot;
  logic              sw_long, setlen_long, walk_last;
  logic [SEG_ADDR_W-1:0] put_addr;

  assign id_ext    = CMP_W'(cmd_q.segment_id);
  assign id_slot   = slot_of(cmd_q.segment_id);
  assign id_mapped = (id_ext != '0) && (id_ext <= CMP_W'(MAX_SEGMENTS))
                     && mapped_q[id_slot];
  assign ofs_in_seg = CMP_W'(cmd_q.offset) < CMP_W'(len_rdata_i);
  assign ofs_in_prg = CMP_W'(cmd_q.offset) < CMP_W'(plen_q);
  assign map_long   = CMP_W'(cmd_q.length) > CMP_W'(SEGMENT_WORDS);
  assign map_pop    = count_q != '0;
  assign map_fresh  = fresh_q < CNT_W'(MAX_SEGMENTS);
  assign map_ok     = !map_long && (map_pop || map_fresh);
  assign map_slot   = map_pop ? stk_rdata_i : fresh_q[SLOT_W-1:0];
  assign sw_long    = CMP_W'(len_rdata_i) > CMP_W'(PROGRAM_WORDS);
  assign setlen_long = CMP_W'(cmd_q.length) > CMP_W'(PROGRAM_WORDS);
  assign walk_last  = wcnt_q == (wlen_q - SEG_LEN_W'(1));
  assign put_addr   = base_of(id_slot) + SEG_ADDR_W'(cmd_q.offset);

  assign idle_o = state_q == S_IDLE;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (start_i) state_d = S_LOOK;
      S_LOOK: begin
        state_d = S_IDLE;
        unique case (cmd_e'(cmd_q.command))
          CMD_MAP:     if (map_ok && cmd_q.length != '0) state_d = S_FILL;
          CMD_GET:     if (id_mapped && ofs_in_seg) state_d = S_READ;
          CMD_GET_PRG: if (ofs_in_prg) state_d = S_READ;
          CMD_SWITCH: begin
            if (id_mapped && !sw_long && len_rdata_i != '0) state_d = S_COPY;
          end
          CMD_UNMAP, CMD_PUT, CMD_PUT_PRG, CMD_SET_LEN: state_d = S_IDLE;
        endcase
      end
      S_FILL:  if (walk_last) state_d = S_IDLE;
      S_READ:  state_d = S_IDLE;
      S_COPY:  if (walk_last) state_d = S_DRAIN;
      S_DRAIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    cmd_d      = cmd_q;
    slot_d     = slot_q;
    base_d     = base_q;
    wcnt_d     = wcnt_q;
    wlen_d     = wlen_q;
    mapped_d   = mapped_q;
    count_d    = count_q;
    fresh_d    = fresh_q;
    plen_d     = plen_q;
    cp_wr_d    = 1'b0;
    cp_waddr_d = cp_waddr_q;
    rd_prg_d   = rd_prg_q;
    rsp_o      = '0;

    seg_req_o       = '0;
    seg_req_o.raddr = base_q + SEG_ADDR_W'(wcnt_q);
    // copy writes land in the cycle after their read
    prg_req_o       = '0;
    prg_req_o.we    = cp_wr_q;
    prg_req_o.waddr = cp_waddr_q;
    prg_req_o.wdata = seg_rdata_i;
    prg_req_o.raddr = PRG_ADDR_W'(cmd_q.offset);
    len_req_o       = '0;
    len_req_o.raddr = slot_of(cmd_i.segment_id);
    stk_req_o       = '0;
    stk_req_o.raddr = SLOT_W'(count_q - CNT_W'(1));

    unique case (state_q)
      S_IDLE: if (start_i) cmd_d = cmd_i;
      S_LOOK: begin
        unique case (cmd_e'(cmd_q.command))
          CMD_MAP: begin
            if (map_long) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_TOO_LONG;
            end else if (!map_ok) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_NO_FREE;
            end else begin
              if (map_pop) count_d = count_q - CNT_W'(1);
              else         fresh_d = fresh_q + CNT_W'(1);
              mapped_d[map_slot] = 1'b1;
              len_req_o.we    = 1'b1;
              len_req_o.waddr = map_slot;
              len_req_o.wdata = SEG_LEN_W'(cmd_q.length);
              slot_d = map_slot;
              base_d = base_of(map_slot);
              wcnt_d = '0;
              wlen_d = SEG_LEN_W'(cmd_q.length);
              if (cmd_q.length == '0) begin
                rsp_o.done   = 1'b1;
                rsp_o.status = ST_OK;
                rsp_o.data   = DATA_W'(map_slot) + DATA_W'(1);
              end
            end
          end
          CMD_UNMAP: begin
            rsp_o.done = 1'b1;
            if (!id_mapped) begin
              rsp_o.status = ST_NOT_MAPPED;
            end else begin
              rsp_o.status = ST_OK;
              mapped_d[id_slot] = 1'b0;
              if (count_q < CNT_W'(MAX_SEGMENTS)) begin
                stk_req_o.we    = 1'b1;
                stk_req_o.waddr = count_q[SLOT_W-1:0];
                stk_req_o.wdata = id_slot;
                count_d = count_q + CNT_W'(1);
              end
            end
          end
          CMD_PUT, CMD_GET: begin
            seg_req_o.raddr = put_addr;
            rd_prg_d = 1'b0;
            if (!id_mapped) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_NOT_MAPPED;
            end else if (!ofs_in_seg) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_OFFSET;
            end else if (cmd_e'(cmd_q.command) == CMD_PUT) begin
              seg_req_o.we    = 1'b1;
              seg_req_o.waddr = put_addr;
              seg_req_o.wdata = cmd_q.value;
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_OK;
            end
          end
          CMD_PUT_PRG, CMD_GET_PRG: begin
            rd_prg_d = 1'b1;
            if (!ofs_in_prg) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_OFFSET;
            end else if (cmd_e'(cmd_q.command) == CMD_PUT_PRG) begin
              prg_req_o.we    = 1'b1;
              prg_req_o.waddr = PRG_ADDR_W'(cmd_q.offset);
              prg_req_o.wdata = cmd_q.value;
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_OK;
            end
          end
          CMD_SWITCH: begin
            if (!id_mapped) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_NOT_MAPPED;
            end else if (sw_long) begin
              rsp_o.done   = 1'b1;
              rsp_o.status = ST_TOO_LONG;
            end else begin
              plen_d = PRG_LEN_W'(len_rdata_i);
              base_d = base_of(id_slot);
              wcnt_d = '0;
              wlen_d = len_rdata_i;
              if (len_rdata_i == '0) begin
                rsp_o.done   = 1'b1;
                rsp_o.status = ST_OK;
              end
            end
          end
          CMD_SET_LEN: begin
            rsp_o.done = 1'b1;
            if (setlen_long) begin
              rsp_o.status = ST_TOO_LONG;
            end else begin
              rsp_o.status = ST_OK;
              plen_d = PRG_LEN_W'(cmd_q.length);
            end
          end
        endcase
      end
      S_FILL: begin
        seg_req_o.we    = 1'b1;
        seg_req_o.waddr = base_q + SEG_ADDR_W'(wcnt_q);
        seg_req_o.wdata = cmd_q.value;
        wcnt_d = wcnt_q + SEG_LEN_W'(1);
        if (walk_last) begin
          rsp_o.done   = 1'b1;
          rsp_o.status = ST_OK;
          rsp_o.data   = DATA_W'(slot_q) + DATA_W'(1);
        end
      end
      S_READ: begin
        rsp_o.done   = 1'b1;
        rsp_o.status = ST_OK;
        rsp_o.data   = rd_prg_q ? prg_rdata_i : seg_rdata_i;
      end
      S_COPY: begin
        cp_wr_d    = 1'b1;
        cp_waddr_d = PRG_ADDR_W'(wcnt_q);
        wcnt_d     = wcnt_q + SEG_LEN_W'(1);
      end
      S_DRAIN: begin
        rsp_o.done   = 1'b1;
        rsp_o.status = ST_OK;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      mapped_q <= '0;
      count_q  <= '0;
      fresh_q  <= '0;
      plen_q   <= '0;
      cp_wr_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      mapped_q <= mapped_d;
      count_q  <= count_d;
      fresh_q  <= fresh_d;
      plen_q   <= plen_d;
      cp_wr_q  <= cp_wr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    slot_q     <= slot_d;
    base_q     <= base_d;
    wcnt_q     <= wcnt_d;
    wlen_q     <= wlen_d;
    cp_waddr_q <= cp_waddr_d;
    rd_prg_q   <= rd_prg_d;
  end

  a_fresh_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CNT_W'(MAX_SEGMENTS))
    else $error("fresh slot mark beyond slot count");
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= fresh_q)
    else $error("free stack holds more slots than were ever used");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> state_q == S_IDLE)
    else $error("command started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.done |=> state_q == S_IDLE)
    else $error("sequencer did not return to idle after a result");
  a_copy_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cp_wr_q |-> $past(state_q) == S_COPY)
    else $error("copy write without a copy read");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: segment id allocator unit testbench
// Drives command beats through the command channel, predicts every response
// beat with a behavioral copy of the memory, allocator and program segment,
// and compares each response beat field by field in arrival order.
// ----------------------------------------------------------------------------
import smia_pkg::*;

typedef struct {
  status_e     st;
  logic [31:0] data;
} reply_t;

// Behavioral copy of the block plus the queue of replies still owed.
class segment_scoreboard;
  logic [31:0] seg_mem [SEG_DEPTH];
  int          seg_len [MAX_SEGMENTS];
  bit          mapped [MAX_SEGMENTS];
  int          free_stack [MAX_SEGMENTS];
  int          free_cnt;
  int          fresh;
  logic [31:0] prg_mem [PROGRAM_WORDS];
  bit          prg_written [PROGRAM_WORDS];
  int          prg_len;
  reply_t      owed [$];
  int          errors;

  function new();
    free_cnt = 0;
    fresh    = 0;
    prg_len  = 0;
    errors   = 0;
    foreach (mapped[i]) mapped[i] = 0;
    foreach (prg_written[i]) prg_written[i] = 0;
  endfunction

  function bit owns(int id, output int slot);
    slot = 0;
    if (id == 0 || id > MAX_SEGMENTS) return 0;
    if (!mapped[id-1]) return 0;
    slot = id - 1;
    return 1;
  endfunction

  // Work out the reply for one accepted command beat and update the copy.
  function void note_command(cmd_t c);
    reply_t r;
    int     slot;
    int     ofs;
    int     len;
    r.st   = ST_OK;
    r.data = '0;
    ofs    = c.offset;
    len    = c.length;
    slot   = 0;
    case (cmd_e'(c.command))
      CMD_MAP: begin
        if (len > SEGMENT_WORDS) r.st = ST_TOO_LONG;
        else if (free_cnt > 0) begin
          free_cnt--;
          slot = free_stack[free_cnt];
        end else if (fresh < MAX_SEGMENTS) begin
          slot = fresh;
          fresh++;
        end else r.st = ST_NO_FREE;
        if (r.st == ST_OK) begin
          for (int i = 0; i < len; i++) seg_mem[slot*SEGMENT_WORDS + i] = c.value;
          seg_len[slot] = len;
          mapped[slot]  = 1;
          r.data        = slot + 1;
        end
      end
      CMD_UNMAP: begin
        if (!owns(c.segment_id, slot)) r.st = ST_NOT_MAPPED;
        else begin
          mapped[slot] = 0;
          if (free_cnt < MAX_SEGMENTS) begin
            free_stack[free_cnt] = slot;
            free_cnt++;
          end
        end
      end
      CMD_PUT, CMD_GET: begin
        if (!owns(c.segment_id, slot)) r.st = ST_NOT_MAPPED;
        else if (ofs >= seg_len[slot]) r.st = ST_OFFSET;
        else if (cmd_e'(c.command) == CMD_PUT) seg_mem[slot*SEGMENT_WORDS + ofs] = c.value;
        else r.data = seg_mem[slot*SEGMENT_WORDS + ofs];
      end
      CMD_PUT_PRG, CMD_GET_PRG: begin
        if (ofs >= prg_len) r.st = ST_OFFSET;
        else if (cmd_e'(c.command) == CMD_PUT_PRG) begin
          prg_mem[ofs]     = c.value;
          prg_written[ofs] = 1;
        end else r.data = prg_mem[ofs];
      end
      CMD_SWITCH: begin
        if (!owns(c.segment_id, slot)) r.st = ST_NOT_MAPPED;
        else if (seg_len[slot] > PROGRAM_WORDS) r.st = ST_TOO_LONG;
        else begin
          for (int i = 0; i < seg_len[slot]; i++) begin
            prg_mem[i]     = seg_mem[slot*SEGMENT_WORDS + i];
            prg_written[i] = 1;
          end
          prg_len = seg_len[slot];
        end
      end
      default: begin
        if (len > PROGRAM_WORDS) r.st = ST_TOO_LONG;
        else prg_len = len;
      end
    endcase
    owed.push_back(r);
  endfunction

  function void check_reply(logic [ST_W-1:0] st, logic [31:0] data);
    reply_t r;
    if (owed.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected reply: status %0d data %h", st, data);
      return;
    end
    r = owed.pop_front();
    if (st !== r.st || data !== r.data) begin
      errors++;
      if (errors <= 10)
        $display("reply mismatch: expected status %0d data %h, got status %0d data %h",
                 r.st, r.data, st, data);
    end
  endfunction
endclass

module tb;
  localparam int LIMIT   = 2_000_000;
  localparam int N_RAND  = 2000;
  localparam int HOLD_AT = 1000;   // beat count that triggers the long stall
  localparam int HOLD_CY = 400;

  logic clk_i;
  logic rst_ni;
  int   cycles;
  int   n_sent;
  bit   held;
  int   hold_left;

  smia_cmd_if cmd_bus ();
  smia_rsp_if rsp_bus ();

  segmented_memory_id_allocator_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_bus),
    .rsp_o  (rsp_bus)
  );

  segment_scoreboard sb = new();

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // No random idling while this window of beats is in flight.
  function automatic bit quiet_window();
    return n_sent >= 600 && n_sent < 900;
  endfunction

  // Response side: check each beat, stall at random, and once hold off long
  // enough that the response register fills and the command side backs up.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_bus.valid && rsp_bus.ready) sb.check_reply(rsp_bus.status, rsp_bus.data);
      if (!held && n_sent >= HOLD_AT) begin
        held      = 1;
        hold_left = HOLD_CY;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (quiet_window()) begin
        rsp_bus.ready <= 1'b1;
      end else begin
        rsp_bus.ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  // One command beat: random idle cycles first, then hold valid until taken.
  task automatic send(cmd_t c);
    while (!quiet_window() && $urandom_range(99) < 35) begin
      cmd_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.command    <= c.command;
    cmd_bus.segment_id <= c.segment_id;
    cmd_bus.offset     <= c.offset;
    cmd_bus.length     <= c.length;
    cmd_bus.value      <= c.value;
    do @(posedge clk_i); while (!cmd_bus.ready);
    sb.note_command(c);
    n_sent++;
  endtask

  function automatic cmd_t mk(cmd_e op, int id, int ofs, int len, logic [31:0] val);
    cmd_t c;
    c.command    = op;
    c.segment_id = ID_W'(id);
    c.offset     = OFS_W'(ofs);
    c.length     = LEN_W'(len);
    c.value      = val;
    return c;
  endfunction

  // Pick a live id most of the time so commands get past the id check.
  function automatic int pick_id();
    int live [$];
    for (int i = 0; i < MAX_SEGMENTS; i++) if (sb.mapped[i]) live.push_back(i + 1);
    if (live.size() > 0 && $urandom_range(99) < 85) return live[$urandom_range(live.size()-1)];
    return $urandom_range(127);
  endfunction

  // Random command shaped by the current copy of the block. Phases alternate
  // between filling the slot table and draining it, so the no-free-slot
  // case and deep free stack reuse both get exercised.
  function automatic cmd_t gen_random(int k);
    cmd_t        c;
    int          roll;
    int          id;
    int          slot;
    int          ofs;
    int          len;
    bit          filling;
    logic [31:0] val;
    filling = ((k / 300) % 2) == 0;
    roll    = $urandom_range(99);
    val     = $urandom();
    ofs     = $urandom_range(4095);
    if (roll < (filling ? 45 : 15)) begin
      case ($urandom_range(9))
        0:       len = SEGMENT_WORDS;
        1:       len = $urandom_range(8191, SEGMENT_WORDS + 1);
        2:       len = $urandom_range(SEGMENT_WORDS - 1, 9);
        default: len = $urandom_range(8);
      endcase
      return mk(CMD_MAP, 0, ofs, len, val);
    end
    if (roll < (filling ? 50 : 40)) return mk(CMD_UNMAP, pick_id(), ofs, 0, val);
    if (roll < 80) begin
      id = pick_id();
      if (sb.owns(id, slot) && sb.seg_len[slot] > 0 && $urandom_range(99) < 85)
        ofs = $urandom_range(sb.seg_len[slot] - 1);
      return mk($urandom_range(1) ? CMD_PUT : CMD_GET, id, ofs, 0, val);
    end
    if (roll < 92) begin
      if (sb.prg_len > 0 && $urandom_range(99) < 85) ofs = $urandom_range(sb.prg_len - 1);
      // never read a program word that was not written yet
      if ($urandom_range(1) && !(ofs < sb.prg_len && !sb.prg_written[ofs]))
        return mk(CMD_GET_PRG, 0, ofs, 0, val);
      return mk(CMD_PUT_PRG, 0, ofs, 0, val);
    end
    if (roll < 96) return mk(CMD_SWITCH, pick_id(), ofs, 0, val);
    len = ($urandom_range(9) == 0) ? $urandom_range(8191) : $urandom_range(PROGRAM_WORDS);
    return mk(CMD_SET_LEN, 0, ofs, len, val);
  endfunction

  initial begin
    cmd_t dir [$];
    rst_ni             = 1'b0;
    cycles             = 0;
    n_sent             = 0;
    held               = 0;
    hold_left          = 0;
    cmd_bus.valid      = 1'b0;
    cmd_bus.command    = '0;
    cmd_bus.segment_id = '0;
    cmd_bus.offset     = '0;
    cmd_bus.length     = '0;
    cmd_bus.value      = '0;
    rsp_bus.ready      = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: field extremes, every command, each error status but no free slot
    dir.push_back(mk(CMD_SET_LEN, 0, 0, PROGRAM_WORDS, 0));
    dir.push_back(mk(CMD_SET_LEN, 0, 0, PROGRAM_WORDS + 1, 0));   // too long
    dir.push_back(mk(CMD_PUT_PRG, 0, 0, 0, 32'hFFFF_FFFF));
    dir.push_back(mk(CMD_PUT_PRG, 0, 4095, 0, 32'h0));
    dir.push_back(mk(CMD_GET_PRG, 0, 0, 0, 0));
    dir.push_back(mk(CMD_GET_PRG, 0, 4095, 0, 0));
    dir.push_back(mk(CMD_SET_LEN, 0, 0, 0, 0));                   // words kept
    dir.push_back(mk(CMD_GET_PRG, 0, 0, 0, 0));                   // now out of range
    dir.push_back(mk(CMD_MAP, 0, 0, SEGMENT_WORDS + 1, 0));       // too long
    dir.push_back(mk(CMD_MAP, 0, 0, 8191, 0));
    dir.push_back(mk(CMD_MAP, 0, 0, 0, 32'h1234_5678));           // empty segment
    dir.push_back(mk(CMD_GET, 1, 0, 0, 0));                       // offset error
    dir.push_back(mk(CMD_MAP, 0, 0, SEGMENT_WORDS, 32'hA5A5_A5A5));
    dir.push_back(mk(CMD_PUT, 2, 255, 0, 32'h5A5A_5A5A));
    dir.push_back(mk(CMD_GET, 2, 255, 0, 0));
    dir.push_back(mk(CMD_GET, 2, 254, 0, 0));
    dir.push_back(mk(CMD_GET, 2, 256, 0, 0));
    dir.push_back(mk(CMD_GET, 0, 0, 0, 0));                       // id zero
    dir.push_back(mk(CMD_PUT, 64, 0, 0, 0));                      // unmapped id
    dir.push_back(mk(CMD_UNMAP, 1, 0, 0, 0));
    dir.push_back(mk(CMD_UNMAP, 1, 0, 0, 0));                     // already free
    dir.push_back(mk(CMD_MAP, 0, 0, 3, 32'hDEAD_BEEF));           // reuses slot 0
    dir.push_back(mk(CMD_SWITCH, 2, 0, 0, 0));
    dir.push_back(mk(CMD_GET_PRG, 0, 255, 0, 0));
    dir.push_back(mk(CMD_SWITCH, 127, 0, 0, 0));
    foreach (dir[i]) send(dir[i]);

    for (int k = 0; k < N_RAND; k++) send(gen_random(k));
    cmd_bus.valid <= 1'b0;

    // drain, then allow the longest command latency for stray beats
    while (sb.owed.size() != 0) @(posedge clk_i);
    repeat (2 * SEGMENT_WORDS) @(posedge clk_i);

    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
